@@ hdl/ist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the integer set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } ctrl_stat_t;

endpackage

@@ hdl/ist_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer that takes one request word and then executes it.
// ----------------------------------------------------------------------------
module ist_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ist_pkg::ctrl_stat_t stat,
    output ist_pkg::ctrl_cmd_t  cmd
);
    import ist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The execute step waits while an earlier result still sits unread.
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.latch = 1'b0;
        cmd.exec  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = !stat.out_stall;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/ist_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_datapath
// Member table, parallel compare cells, shift network and result register.
// ----------------------------------------------------------------------------
module ist_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 operation,
    input  logic signed [31:0]         value,
    input  ist_pkg::ctrl_cmd_t         cmd,
    output ist_pkg::ctrl_stat_t        stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       success,
    output logic                       full_reject,
    output logic [ist_pkg::COUNT_W-1:0] count
);
    import ist_pkg::*;

    logic [DATA_W-1:0] store_reg  [CAPACITY];
    logic [DATA_W-1:0] store_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    op_t               op_reg;
    logic [DATA_W-1:0] value_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              success_reg;
    logic              full_reg;
    logic              ok_next;
    logic              full_next;

    logic [CAPACITY-1:0] match;
    logic                present;
    logic [IDX_W-1:0]    hit_idx;

    // Request latch; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= op_t'(operation);
            value_reg <= value;
        end
    end

    // One compare cell per entry; only live entries take part.
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            match[k] = (store_reg[k] == value_reg) && (CNT_W'(k) < count_reg);
        end
    end

    assign present = |match;

    always_comb
    begin
        hit_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        full_next  = 1'b0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            store_next[k] = store_reg[k];
        end
        case (op_reg)
            OP_INSERT:
            begin
                if (!present)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        store_next[count_reg[IDX_W-1:0]] = value_reg;
                        count_next = CNT_W'(count_reg + 1'b1);
                        ok_next    = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            OP_ERASE:
            begin
                if (present)
                begin
                    // Every entry from the hit up to the next-to-last takes its upper neighbor.
                    for (int k = 0; k < CAPACITY - 1; k++)
                    begin
                        if (IDX_W'(k) >= hit_idx)
                        begin
                            store_next[k] = store_reg[k + 1];
                        end
                    end
                    count_next = CNT_W'(count_reg - 1'b1);
                    ok_next    = 1'b1;
                end
            end
            OP_FIND:
            begin
                ok_next = present;
            end
            OP_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                store_reg[k] <= store_next[k];
            end
            success_reg <= ok_next;
            full_reg    <= full_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign success        = success_reg;
    assign full_reject    = full_reg;
    assign count          = COUNT_W'(count_reg);

endmodule

@@ hdl/integer_set_table.sv @@
`timescale 1ns / 1ps
// A result word is registered in the execute state that follows the request
// latch; the execute step waits while an earlier result is still unread.
// No new request is taken until the current one has executed; the compare
// cells and the gap shift all work in the execute state after the request latch.
// Reset (rst_n, asynchronous, active low) empties the set and drops out_valid.
// The member table itself is not cleared; entries past the count are never read.
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct 32-bit signed integers kept packed in a fixed table.
// ----------------------------------------------------------------------------
module integer_set_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic signed [31:0]          value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        success,
    output logic                        full_reject,
    output logic [ist_pkg::COUNT_W-1:0] count
);
    import ist_pkg::*;

    // The controller only sequences: it accepts a word in the idle state and
    // fires one execute pulse, held back while the result register is still
    // occupied by an unread word. All table work lives in the datapath.
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath compares the key against every live entry at once, then
    // appends, shifts down to close a gap, resets the count or reports a find. The
    // result register lets the next request be accepted while a result waits.
    ist_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .success     (success),
        .full_reject (full_reject),
        .count       (count)
    );

endmodule

@@ hdl/ist_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks for the integer set table.
// ----------------------------------------------------------------------------
module ist_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        success,
    input logic                        full_reject,
    input logic [ist_pkg::COUNT_W-1:0] count
);
    import ist_pkg::*;

    // A rejected insert never reports success.
    a_reject_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_reject) |-> !success)
        else $error("full_reject with success");

    // A full rejection only happens at capacity.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_reject) |-> (count == COUNT_W'(CAPACITY)))
        else $error("full_reject below capacity");

    // Requests are taken one at a time, so ready drops after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted back to back");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(count) && $stable(success) && $stable(full_reject)))
        else $error("stalled result changed");

endmodule

bind integer_set_table ist_checker u_ist_checker (.*);
